[src/tfhl_pkg.sv]
// shared types and codes for the two-field history floor lookup
`default_nettype none
package tfhl_pkg;

  localparam int REQ_BITS    = 2;
  localparam int YEAR_BITS   = 16;
  localparam int ID_BITS     = 16;
  localparam int STATUS_BITS = 3;

  localparam logic [REQ_BITS-1:0] REQ_SET_FIRST = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_SET_LAST  = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_QUERY     = 2'd2;

  localparam logic [STATUS_BITS-1:0] STAT_NONE    = 3'd0;
  localparam logic [STATUS_BITS-1:0] STAT_LAST    = 3'd1;
  localparam logic [STATUS_BITS-1:0] STAT_FIRST   = 3'd2;
  localparam logic [STATUS_BITS-1:0] STAT_BOTH    = 3'd3;
  localparam logic [STATUS_BITS-1:0] STAT_WR_OK   = 3'd4;
  localparam logic [STATUS_BITS-1:0] STAT_WR_FULL = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic finish;
  } tfhl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic cmp_busy;
    logic out_free;
  } tfhl_sts_t;

endpackage
`default_nettype wire

[src/tfhl_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module tfhl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[src/tfhl_ctrl.sv]
// controller state machine: accept, scan the tables, finish the word
`default_nettype none
module tfhl_ctrl
  import tfhl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire tfhl_sts_t sts,
  output tfhl_cmd_t      cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = !sts.scan_done;
        // wait for the last read to pass the compare stage
        if (sts.scan_done && !sts.cmp_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/tfhl_dp.sv]
// datapath: table rams, entry scan, floor and match compare, result register
`default_nettype none
module tfhl_dp
  import tfhl_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tfhl_cmd_t              cmd,
  output tfhl_sts_t                   sts,
  input  wire logic [REQ_BITS-1:0]    in_req_type,
  input  wire logic [YEAR_BITS-1:0]   in_year,
  input  wire logic [ID_BITS-1:0]     in_name_id,
  input  wire logic                   out_stall,
  output logic                        out_valid,
  output logic [STATUS_BITS-1:0]      out_status,
  output logic [ID_BITS-1:0]          out_first_id,
  output logic [ID_BITS-1:0]          out_last_id
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);
  localparam int RW = KEY_BITS + ID_BITS;
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  logic [REQ_BITS-1:0] req_r;
  logic [KEY_BITS-1:0] key_r;
  logic [ID_BITS-1:0]  id_r;
  logic [CW-1:0]       idx_r;
  logic                cmp_vld_r;
  logic [CW-1:0]       cmp_idx_r;
  logic [CW-1:0]       fcnt_r;
  logic [CW-1:0]       lcnt_r;
  logic                f_found_r;
  logic [KEY_BITS-1:0] f_best_r;
  logic [ID_BITS-1:0]  f_val_r;
  logic                l_found_r;
  logic [KEY_BITS-1:0] l_best_r;
  logic [ID_BITS-1:0]  l_val_r;
  logic                hit_r;
  logic [AW-1:0]       hit_idx_r;
  logic                out_valid_r;
  logic [STATUS_BITS-1:0] out_status_r;
  logic [ID_BITS-1:0]  out_first_r;
  logic [ID_BITS-1:0]  out_last_r;

  logic [31:0]         year_ext;
  logic                is_write;
  logic                wr_first;
  logic [CW-1:0]       scan_len;
  logic [RW-1:0]       f_rd;
  logic [RW-1:0]       l_rd;
  logic [KEY_BITS-1:0] f_key;
  logic [KEY_BITS-1:0] l_key;
  logic                f_ok;
  logic                l_ok;
  logic [KEY_BITS-1:0] tgt_key;
  logic                tgt_ok;
  logic [CW-1:0]       tgt_cnt;
  logic                wr_allow;
  logic [AW-1:0]       wr_addr;
  logic                f_we;
  logic                l_we;
  logic [STATUS_BITS-1:0] q_status;

  assign year_ext = {{(32 - YEAR_BITS){1'b0}}, in_year};
  assign is_write = (req_r == REQ_SET_FIRST) || (req_r == REQ_SET_LAST);
  assign wr_first = (req_r == REQ_SET_FIRST);

  always_comb begin
    if (is_write) begin
      scan_len = wr_first ? fcnt_r : lcnt_r;
    end else begin
      scan_len = (fcnt_r > lcnt_r) ? fcnt_r : lcnt_r;
    end
  end

  assign sts.scan_done = (idx_r >= scan_len);
  assign sts.cmp_busy  = cmp_vld_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  // compare stage on the registered ram words
  assign f_key   = f_rd[RW-1:ID_BITS];
  assign l_key   = l_rd[RW-1:ID_BITS];
  assign f_ok    = cmp_vld_r && (cmp_idx_r < fcnt_r);
  assign l_ok    = cmp_vld_r && (cmp_idx_r < lcnt_r);
  assign tgt_key = wr_first ? f_key : l_key;
  assign tgt_ok  = wr_first ? f_ok : l_ok;
  assign tgt_cnt = wr_first ? fcnt_r : lcnt_r;

  // existing key overwrites even in a full table
  assign wr_allow = hit_r || (tgt_cnt < FULL);
  assign wr_addr  = hit_r ? hit_idx_r : tgt_cnt[AW-1:0];
  assign f_we     = cmd.finish && is_write && wr_first && wr_allow;
  assign l_we     = cmd.finish && is_write && !wr_first && wr_allow;

  always_comb begin
    if (f_found_r) begin
      q_status = l_found_r ? STAT_BOTH : STAT_FIRST;
    end else begin
      q_status = l_found_r ? STAT_LAST : STAT_NONE;
    end
  end

  tfhl_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_first_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (wr_addr),
    .wdata ({key_r, id_r}),
    .raddr (idx_r[AW-1:0]),
    .rdata (f_rd)
  );

  tfhl_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_last_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (wr_addr),
    .wdata ({key_r, id_r}),
    .raddr (idx_r[AW-1:0]),
    .rdata (l_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      fcnt_r      <= '0;
      lcnt_r      <= '0;
      f_found_r   <= 1'b0;
      l_found_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.issue;
      if (cmd.accept) begin
        idx_r     <= '0;
        f_found_r <= 1'b0;
        l_found_r <= 1'b0;
        hit_r     <= 1'b0;
      end else begin
        if (cmd.issue) begin
          idx_r <= idx_r + 1'b1;
        end
        if (is_write) begin
          if (tgt_ok && (tgt_key == key_r)) begin
            hit_r <= 1'b1;
          end
        end else begin
          if (f_ok && (f_key <= key_r) && (!f_found_r || (f_key > f_best_r))) begin
            f_found_r <= 1'b1;
          end
          if (l_ok && (l_key <= key_r) && (!l_found_r || (l_key > l_best_r))) begin
            l_found_r <= 1'b1;
          end
        end
      end
      if (cmd.finish && is_write && !hit_r && (tgt_cnt < FULL)) begin
        if (wr_first) begin
          fcnt_r <= fcnt_r + 1'b1;
        end else begin
          lcnt_r <= lcnt_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (cmd.accept) begin
      req_r <= in_req_type;
      key_r <= year_ext[KEY_BITS-1:0];
      id_r  <= in_name_id;
    end
    if (!cmd.accept && is_write && tgt_ok && (tgt_key == key_r)) begin
      hit_idx_r <= cmp_idx_r[AW-1:0];
    end
    if (!cmd.accept && !is_write && f_ok && (f_key <= key_r)
        && (!f_found_r || (f_key > f_best_r))) begin
      f_best_r <= f_key;
      f_val_r  <= f_rd[ID_BITS-1:0];
    end
    if (!cmd.accept && !is_write && l_ok && (l_key <= key_r)
        && (!l_found_r || (l_key > l_best_r))) begin
      l_best_r <= l_key;
      l_val_r  <= l_rd[ID_BITS-1:0];
    end
    if (cmd.finish) begin
      if (is_write) begin
        out_status_r <= wr_allow ? STAT_WR_OK : STAT_WR_FULL;
        out_first_r  <= '0;
        out_last_r   <= '0;
      end else begin
        out_status_r <= q_status;
        out_first_r  <= f_found_r ? f_val_r : '0;
        out_last_r   <= l_found_r ? l_val_r : '0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_first_id = out_first_r;
  assign out_last_id  = out_last_r;

  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fcnt_r <= FULL) && (lcnt_r <= FULL))
    else $error("table count above capacity");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (cmp_idx_r < scan_len))
    else $error("compare stage beyond scan length");

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!cmp_vld_r && sts.scan_done))
    else $error("finish before scan drained");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((fcnt_r == $past(fcnt_r)) || (fcnt_r == $past(fcnt_r) + 1'b1)))
    else $error("first count jumped");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while held");

endmodule
`default_nettype wire

[src/two_field_history_floor_lookup.sv]
// top level: floor lookup over first-value and last-value year tables
//
//   channel  ports                                   direction
//   in       in_valid in_stall in_req_type in_year in_name_id     into block
//   out      out_valid out_stall out_status out_first_id out_last_id  out of block
//
// a word is taken when idle, and its result shows in the same cycle that the next word can
// first be taken; the scan covers the scanned table's entry count for a write and the larger
// of the two counts for a query, entry by entry since each table has one ram read port.
// a write or query finishes only when the result register is free.
// synchronous active-low reset empties both tables (counts to zero).
// a stalled result is held in the output register while the next word is taken.
`default_nettype none
module two_field_history_floor_lookup
  import tfhl_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [REQ_BITS-1:0]     in_req_type,
  input  wire logic [YEAR_BITS-1:0]    in_year,
  input  wire logic [ID_BITS-1:0]      in_name_id,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [STATUS_BITS-1:0]       out_status,
  output logic [ID_BITS-1:0]           out_first_id,
  output logic [ID_BITS-1:0]           out_last_id
);

  tfhl_cmd_t cmd;
  tfhl_sts_t sts;

  tfhl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tfhl_dp #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_req_type  (in_req_type),
    .in_year      (in_year),
    .in_name_id   (in_name_id),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_first_id (out_first_id),
    .out_last_id  (out_last_id)
  );

endmodule
`default_nettype wire

[dv/two_field_history_floor_lookup_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the two-field history floor lookup with its own table predictor
module two_field_history_floor_lookup_tb
  import tfhl_pkg::*;
();

  localparam int ENTRIES = 16;
  localparam int FIRST_TAB = 0;
  localparam int LAST_TAB = 1;
  localparam logic [REQ_BITS-1:0] REQ_QUERY_ALT = 2'd3;
  localparam int RANDOM_WORDS = 1230;
  localparam int POOL_SIZE = 20;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [REQ_BITS-1:0]  req;
    logic [YEAR_BITS-1:0] year;
    logic [ID_BITS-1:0]   name_id;
    bit                   drain_first;
  } lookup_word_t;

  typedef struct {
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     first_id;
    logic [ID_BITS-1:0]     last_id;
  } lookup_reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [REQ_BITS-1:0]    in_req_type = '0;
  logic [YEAR_BITS-1:0]   in_year = '0;
  logic [ID_BITS-1:0]     in_name_id = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_BITS-1:0] out_status;
  logic [ID_BITS-1:0]     out_first_id;
  logic [ID_BITS-1:0]     out_last_id;

  // predictor state: index 0 is the first-value table, 1 the last-value table
  logic [YEAR_BITS-1:0] tab_key [2][ENTRIES];
  logic [ID_BITS-1:0]   tab_handle [2][ENTRIES];
  int                   tab_fill [2] = '{0, 0};

  lookup_word_t  pending_words[$];
  lookup_reply_t expected_replies[$];
  lookup_word_t  cur_word;
  logic [YEAR_BITS-1:0] key_pool [2][POOL_SIZE];

  int mismatches = 0;
  int replies_seen = 0;
  int gap_left = 0;
  int in_burst = 0;
  int in_flight = 0;
  int stall_left = 0;
  int out_burst = 0;
  int quiet_cycles = 0;

  two_field_history_floor_lookup u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_year      (in_year),
    .in_name_id   (in_name_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_first_id (out_first_id),
    .out_last_id  (out_last_id)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit store_handle(int t, logic [YEAR_BITS-1:0] key,
                                      logic [ID_BITS-1:0] handle);
    for (int i = 0; i < tab_fill[t]; i++) begin
      if (tab_key[t][i] == key) begin
        tab_handle[t][i] = handle;
        return 1'b1;
      end
    end
    if (tab_fill[t] >= ENTRIES) return 1'b0;
    tab_key[t][tab_fill[t]] = key;
    tab_handle[t][tab_fill[t]] = handle;
    tab_fill[t]++;
    return 1'b1;
  endfunction

  // greatest key not above year; a zero handle still counts as found
  function automatic bit floor_handle(int t, logic [YEAR_BITS-1:0] year,
                                      output logic [ID_BITS-1:0] handle);
    bit found;
    logic [YEAR_BITS-1:0] best;
    found = 1'b0;
    best = '0;
    handle = '0;
    for (int i = 0; i < tab_fill[t]; i++) begin
      if (tab_key[t][i] <= year && (!found || tab_key[t][i] > best)) begin
        found = 1'b1;
        best = tab_key[t][i];
        handle = tab_handle[t][i];
      end
    end
    return found;
  endfunction

  function automatic lookup_reply_t predict_reply(lookup_word_t w);
    lookup_reply_t r;
    bit ff;
    bit lf;
    int t;
    r.first_id = '0;
    r.last_id = '0;
    if (w.req == REQ_SET_FIRST || w.req == REQ_SET_LAST) begin
      t = (w.req == REQ_SET_FIRST) ? FIRST_TAB : LAST_TAB;
      r.status = store_handle(t, w.year, w.name_id) ? STAT_WR_OK : STAT_WR_FULL;
    end else begin
      // selector three decodes as a query too
      ff = floor_handle(FIRST_TAB, w.year, r.first_id);
      lf = floor_handle(LAST_TAB, w.year, r.last_id);
      if (ff && lf) r.status = STAT_BOTH;
      else if (ff) r.status = STAT_FIRST;
      else if (lf) r.status = STAT_LAST;
      else r.status = STAT_NONE;
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones, now and then a run with none
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(199);
    if (r == 0) begin
      burst = $urandom_range(80, 30);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 170) return $urandom_range(3, 1);
    if (r < 194) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [ID_BITS-1:0] random_handle();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ID_BITS'($urandom);
  endfunction

  task automatic add_word(logic [REQ_BITS-1:0] req, logic [YEAR_BITS-1:0] year,
                          logic [ID_BITS-1:0] name_id, bit drain_first = 1'b0);
    lookup_word_t w;
    w.req = req;
    w.year = year;
    w.name_id = name_id;
    w.drain_first = drain_first;
    pending_words.push_back(w);
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch on reply %0d: %s", $time, replies_seen, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : drive_words
    bit took;
    bit gave;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      gave = out_valid && !out_stall;
      in_flight += int'(took) - int'(gave);
      if (took) begin
        expected_replies.push_back(predict_reply(cur_word));
        gap_left = pick_gap(in_burst);
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain_first && in_flight != 0)) begin
          cur_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_req_type <= cur_word.req;
          in_year <= cur_word.year;
          in_name_id <= cur_word.name_id;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_replies
    lookup_reply_t exp_reply;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("word with nothing expected, status %0d", out_status));
        end else begin
          exp_reply = expected_replies.pop_front();
          if (out_status !== exp_reply.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status,
                                      exp_reply.status));
          if (out_first_id !== exp_reply.first_id)
            report_mismatch($sformatf("first_id %h, expected %h", out_first_id,
                                      exp_reply.first_id));
          if (out_last_id !== exp_reply.last_id)
            report_mismatch($sformatf("last_id %h, expected %h", out_last_id,
                                      exp_reply.last_id));
        end
        replies_seen++;
      end
      if (stall_left == 0 && $urandom_range(3) == 0) stall_left = pick_gap(out_burst);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("two_field_history_floor_lookup_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : run
    int sel;
    int k;
    int t;
    bit late;
    logic [REQ_BITS-1:0] req;
    logic [YEAR_BITS-1:0] year;
    logic [YEAR_BITS-1:0] base;

    // directed: empty tables, extremes, zero handle, overwrites, selector three
    add_word(REQ_QUERY, 16'h0000, 16'h1357);
    add_word(REQ_QUERY_ALT, 16'hffff, 16'hffff);
    add_word(REQ_SET_FIRST, 16'd100, 16'h0000);
    add_word(REQ_QUERY, 16'd99, 16'h0000);
    add_word(REQ_QUERY, 16'd100, 16'h2468);
    add_word(REQ_SET_LAST, 16'd1, 16'hffff);
    add_word(REQ_QUERY, 16'd1, 16'h0001);
    add_word(REQ_QUERY, 16'hffff, 16'h8000);
    add_word(REQ_SET_FIRST, 16'hffff, 16'h1234);
    add_word(REQ_SET_LAST, 16'hffff, 16'ha5a5);
    add_word(REQ_QUERY, 16'hffff, 16'h0000);
    add_word(REQ_QUERY, 16'hfffe, 16'hffff);
    add_word(REQ_SET_FIRST, 16'd100, 16'h5a5a);
    add_word(REQ_QUERY_ALT, 16'd100, 16'h0000, 1'b1);
    add_word(REQ_SET_LAST, 16'd1, 16'h0000);
    add_word(REQ_QUERY, 16'd50, 16'h7777);
    add_word(REQ_QUERY, 16'h0000, 16'h0000);
    add_word(REQ_SET_FIRST, 16'h8000, 16'h8001);
    add_word(REQ_QUERY, 16'h8000, 16'h0000);
    add_word(REQ_QUERY, 16'h7fff, 16'hffff);

    // key pools a bit larger than a table, so tables fill and new keys get dropped
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[FIRST_TAB][i] = YEAR_BITS'($urandom_range(65535, 1));
      key_pool[LAST_TAB][i] = (i < 6) ? key_pool[FIRST_TAB][i] :
                              YEAR_BITS'($urandom_range(65535, 1));
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sel = $urandom_range(99);
      late = (n > RANDOM_WORDS * 9 / 10);
      if (sel < 30) req = REQ_SET_FIRST;
      else if (sel < 60) req = REQ_SET_LAST;
      else if (sel < 94) req = REQ_QUERY;
      else req = REQ_QUERY_ALT;
      if (req == REQ_SET_FIRST || req == REQ_SET_LAST) begin
        t = (req == REQ_SET_FIRST) ? FIRST_TAB : LAST_TAB;
        k = $urandom_range(19);
        // key zero only near the end, so early queries can still miss
        if (k < 17) year = key_pool[t][$urandom_range(POOL_SIZE - 1)];
        else if (late) year = '0;
        else year = YEAR_BITS'($urandom_range(65535, 1));
      end else begin
        k = $urandom_range(9);
        if (k < 5) begin
          base = key_pool[$urandom_range(1)][$urandom_range(POOL_SIZE - 1)];
          year = base + YEAR_BITS'($urandom_range(2)) - 1'b1;
        end else if (k < 8) begin
          year = YEAR_BITS'($urandom);
        end else if (k == 8) begin
          year = '1;
        end else begin
          year = '0;
        end
      end
      add_word(req, year, random_handle(), n == RANDOM_WORDS / 2);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("two_field_history_floor_lookup_tb: PASS");
    end else begin
      $display("two_field_history_floor_lookup_tb: FAIL");
    end
    $finish;
  end

endmodule
